// ----- rtl/tss_pkg.sv -----
// Shared constants, types and functions of the temperature segment sequencer.
`timescale 1ns / 1ps

package tss_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int MAX_DIGITS_DEF  = 3;

    localparam int ADC_BITS    = 12;
    localparam int S_DATA_W    = 16;
    localparam int SEG_W       = 8;
    localparam int GAIN_W      = 16;
    localparam int OFFSET_W    = 24;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int FRAC_BITS   = 16;

    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd2708;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 24'd1344328;

    // 32 degrees, times 5 for the /5 of the scale, in Q16
    localparam int FAHR_BIAS = 10485760;

    typedef enum logic [0:0] {
        REG_GAIN   = 1'b0,
        REG_OFFSET = 1'b1
    } reg_index_t;

    localparam logic [SEG_W-1:0] SEG_MINUS    = 8'h40;
    localparam logic [SEG_W-1:0] SEG_LETTER_C = 8'h39;
    localparam logic [SEG_W-1:0] SEG_LETTER_F = 8'h71;

    function automatic logic [SEG_W-1:0] seg_digit(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        unique case (digit)
            4'd0: code = 8'h3F;
            4'd1: code = 8'h06;
            4'd2: code = 8'h5B;
            4'd3: code = 8'h4F;
            4'd4: code = 8'h66;
            4'd5: code = 8'h6D;
            4'd6: code = 8'h7D;
            4'd7: code = 8'h07;
            4'd8: code = 8'h7F;
            4'd9: code = 8'h6F;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    function automatic longint pow10(input int n);
        longint acc;
        acc = 1;
        for (int i = 0; i < n; i++) begin
            acc = acc * 10;
        end
        return acc;
    endfunction

endpackage

// ----- rtl/temperature_to_segment_sequence_top.sv -----
// Top level: sensor sample to seven-segment code stream, pipelined.
//
// One transfer on the s_ channel carries a converter sample (s_tdata) and
// the display unit (s_tuser: 0 Celsius, 1 Fahrenheit). The sample is scaled
// with the gain and offset registers of the APB port, converted to an
// integer temperature and sent out on the m_ channel as a run of segment
// codes: minus sign if negative, digits from most significant, then the
// unit letter, which carries m_tlast.
// Throughput: the arithmetic pipeline takes a sample every cycle while the
// m_ channel keeps up; the output serializer sends one code per cycle while
// m_tready is high, and a sample is sent as 2 to MAX_DIGITS + 2 codes, set
// by its number of digits and its sign.
// Reset (aresetn low, synchronous) empties the pipeline and the serializer
// and loads the register defaults. When the receiver holds m_tready low the
// current code holds, the pipeline fills up behind it and s_tready drops;
// nothing is lost or repeated.
`timescale 1ns / 1ps

module temperature_to_segment_sequence_top #(
    parameter int SAMPLE_BITS = tss_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_DIGITS  = tss_pkg::MAX_DIGITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tss_pkg::S_DATA_W-1:0]      s_tdata,   // [11:0] adc_sample, [15:12] zero
    input  logic                              s_tuser,   // [0] unit_select

    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tss_pkg::SEG_W-1:0]         m_tdata,   // [7:0] segment_code
    output logic                              m_tlast,   // last_code

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tss_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tss_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tss_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int MD   = MAX_DIGITS;
    localparam int PW   = SAMPLE_BITS + tss_pkg::GAIN_W;
    localparam int CW   = PW + 1;
    localparam int NW   = CW + 5;
    localparam int QW   = NW - tss_pkg::FRAC_BITS;
    localparam int S5   = QW + 2;
    localparam longint R5 = ((64'sd1 <<< S5) + 4) / 5;
    localparam int M5W  = QW + S5;
    localparam longint LIMIT = tss_pkg::pow10(MAX_DIGITS) - 1;
    localparam int DW   = $clog2(LIMIT + 1);
    localparam int XW   = (QW > DW) ? QW : DW;
    localparam int S10  = DW + 4;
    localparam longint R10 = ((64'sd1 <<< S10) + 9) / 10;
    localparam int M10W = DW + S10;
    localparam int NDW  = $clog2(MD + 1);
    localparam int CN   = MD + 2;
    localparam int SQW  = CN * tss_pkg::SEG_W;
    localparam int CCW  = $clog2(CN + 1);

    localparam int ST_MUL  = 0;
    localparam int ST_SUB  = 1;
    localparam int ST_FAHR = 2;
    localparam int ST_ABS  = 3;
    localparam int ST_DIV  = 4;
    localparam int ST_SAT  = 5;
    localparam int ST_FMT  = ST_SAT + MD + 1;
    localparam int NS      = ST_FMT + 1;

    // configuration registers
    logic [tss_pkg::GAIN_W-1:0]   gain_reg;
    logic [tss_pkg::OFFSET_W-1:0] offset_reg;
    tss_pkg::reg_index_t          reg_idx;
    logic                         cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = tss_pkg::reg_index_t'(paddr[tss_pkg::APB_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= tss_pkg::GAIN_RESET;
            offset_reg <= tss_pkg::OFFSET_RESET;
        end else if (cfg_write) begin
            unique case (reg_idx)
                tss_pkg::REG_GAIN:   gain_reg   <= pwdata[tss_pkg::GAIN_W-1:0];
                tss_pkg::REG_OFFSET: offset_reg <= pwdata[tss_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            tss_pkg::REG_GAIN:   prdata = tss_pkg::APB_DATA_W'(gain_reg);
            tss_pkg::REG_OFFSET: prdata = tss_pkg::APB_DATA_W'(offset_reg);
            default:             prdata = '0;
        endcase
    end

    // pipeline control
    logic vld_reg [0:NS-1];
    logic adv     [0:NS-1];
    logic ser_rdy;

    always_comb begin
        adv[NS-1] = !vld_reg[NS-1] || ser_rdy;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign s_tready = adv[ST_MUL];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NS; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // scale: product, offset, Fahrenheit, magnitude, divide by 5 for Fahrenheit
    logic [SAMPLE_BITS-1:0]  sample;
    logic [PW-1:0]           prod_reg;
    logic                    f0_reg;
    logic signed [CW-1:0]    c_reg;
    logic                    f1_reg;
    logic signed [NW-1:0]    c_ext;
    logic signed [NW-1:0]    num_reg;
    logic                    f2_reg;
    logic [NW-1:0]           mag;
    logic [QW-1:0]           q16_reg;
    logic                    neg3_reg;
    logic                    f3_reg;
    logic [M5W-1:0]          p5;
    logic [QW-1:0]           div_reg;
    logic                    neg4_reg;
    logic                    f4_reg;

    assign sample = SAMPLE_BITS'(s_tdata[tss_pkg::ADC_BITS-1:0]);
    assign c_ext  = NW'(c_reg);
    assign mag    = num_reg[NW-1] ? NW'(-num_reg) : NW'(num_reg);
    assign p5     = M5W'(q16_reg) * M5W'(R5);

    always_ff @(posedge aclk) begin
        if (adv[ST_MUL]) begin
            prod_reg <= PW'(sample) * PW'(gain_reg);
            f0_reg   <= s_tuser;
        end
        if (adv[ST_SUB]) begin
            c_reg  <= CW'(signed'({1'b0, prod_reg})) - CW'(signed'({1'b0, offset_reg}));
            f1_reg <= f0_reg;
        end
        if (adv[ST_FAHR]) begin
            num_reg <= f1_reg ? (c_ext <<< 3) + c_ext + NW'(tss_pkg::FAHR_BIAS) : c_ext;
            f2_reg  <= f1_reg;
        end
        if (adv[ST_ABS]) begin
            q16_reg  <= mag[NW-1:tss_pkg::FRAC_BITS];
            neg3_reg <= num_reg[NW-1];
            f3_reg   <= f2_reg;
        end
        if (adv[ST_DIV]) begin
            div_reg  <= f3_reg ? p5[M5W-1:S5] : q16_reg;
            neg4_reg <= neg3_reg;
            f4_reg   <= f3_reg;
        end
    end

    // digit extraction, least significant digit first
    logic [DW-1:0]   dv_reg    [0:MD-1];
    logic [3:0]      ddig_reg  [0:MD][0:MD-1];
    logic            dneg_reg  [0:MD];
    logic            dfahr_reg [0:MD];
    logic [M10W-1:0] p10       [1:MD];
    logic [DW-1:0]   quo       [1:MD];
    logic [DW-1:0]   rem       [1:MD];

    always_comb begin
        for (int k = 1; k <= MD; k++) begin
            p10[k] = M10W'(dv_reg[k-1]) * M10W'(R10);
            quo[k] = p10[k][M10W-1:S10];
            rem[k] = dv_reg[k-1] - ((quo[k] << 3) + (quo[k] << 1));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_SAT]) begin
            dv_reg[0]    <= (XW'(div_reg) > XW'(LIMIT)) ? DW'(LIMIT) : DW'(div_reg);
            dneg_reg[0]  <= neg4_reg && (div_reg != '0);
            dfahr_reg[0] <= f4_reg;
            for (int i = 0; i < MD; i++) begin
                ddig_reg[0][i] <= 4'd0;
            end
        end
        for (int k = 1; k < MD; k++) begin
            if (adv[ST_SAT + k]) begin
                dv_reg[k] <= quo[k];
            end
        end
        for (int k = 1; k <= MD; k++) begin
            if (adv[ST_SAT + k]) begin
                dneg_reg[k]  <= dneg_reg[k-1];
                dfahr_reg[k] <= dfahr_reg[k-1];
                for (int i = 0; i < MD; i++) begin
                    ddig_reg[k][i] <= (i == k - 1) ? rem[k][3:0] : ddig_reg[k-1][i];
                end
            end
        end
    end

    // code sequence: drop leading zeros, add sign and unit letter
    logic [NDW-1:0]  nd;
    logic [SQW-1:0]  rev;
    logic [SQW-1:0]  body;
    logic [SQW-1:0]  seq;
    logic [CCW-1:0]  cnt;
    logic [SQW-1:0]  seq_reg;
    logic [CCW-1:0]  cnt_reg;

    always_comb begin
        nd = NDW'(1);
        for (int i = 1; i < MD; i++) begin
            if (ddig_reg[MD][i] != 4'd0) begin
                nd = NDW'(i + 1);
            end
        end
        rev = '0;
        for (int j = 0; j < MD; j++) begin
            rev[j*tss_pkg::SEG_W +: tss_pkg::SEG_W] = tss_pkg::seg_digit(ddig_reg[MD][MD-1-j]);
        end
        body = (rev >> (tss_pkg::SEG_W * (MD - int'(nd))))
             | (SQW'(dfahr_reg[MD] ? tss_pkg::SEG_LETTER_F : tss_pkg::SEG_LETTER_C)
                << (tss_pkg::SEG_W * int'(nd)));
        seq = dneg_reg[MD] ? ((body << tss_pkg::SEG_W) | SQW'(tss_pkg::SEG_MINUS)) : body;
        cnt = CCW'(nd) + CCW'(1) + CCW'(dneg_reg[MD]);
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_FMT]) begin
            seq_reg <= seq;
            cnt_reg <= cnt;
        end
    end

    // serializer: one code per transfer
    logic [SQW-1:0] code_reg;
    logic [CCW-1:0] left_reg;
    logic           load;

    assign ser_rdy  = (left_reg == '0) || ((left_reg == CCW'(1)) && m_tready);
    assign load     = vld_reg[ST_FMT] && ser_rdy;
    assign m_tvalid = (left_reg != '0);
    assign m_tdata  = code_reg[tss_pkg::SEG_W-1:0];
    assign m_tlast  = (left_reg == CCW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else if (load) begin
            left_reg <= cnt_reg;
        end else if (m_tvalid && m_tready) begin
            left_reg <= left_reg - CCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            code_reg <= seq_reg;
        end else if (m_tvalid && m_tready) begin
            code_reg <= code_reg >> tss_pkg::SEG_W;
        end
    end

endmodule

// ----- rtl/tss_checker.sv -----
// Port checker of the temperature segment sequencer and its bind.
`timescale 1ns / 1ps

module tss_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [tss_pkg::SEG_W-1:0] m_tdata,
    input logic                      m_tlast
);

    // hold a stalled code
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled code changed");

    // drop the output after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // close every run with a unit letter
    a_last_letter: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |->
            (m_tdata == tss_pkg::SEG_LETTER_C) || (m_tdata == tss_pkg::SEG_LETTER_F))
        else $error("last code is not a unit letter");

    // follow a minus sign at once with a digit
    a_minus_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && (m_tdata == tss_pkg::SEG_MINUS) |=> m_tvalid && !m_tlast)
        else $error("minus sign not followed by a digit");

endmodule

bind temperature_to_segment_sequence_top tss_checker u_tss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
